// File: hdl/coap_frame_serializer_defines.svh
// Assertion macros for the CoAP frame serializer.
// Needs clk_i and rst_ni in the scope of use.
`ifndef COAP_FRAME_SERIALIZER_DEFINES_SVH
`define COAP_FRAME_SERIALIZER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cfs_pkg.sv
// Types and constants of the CoAP frame serializer.
// No dependencies; imported by cfs_byte_sel and coap_frame_serializer.
package cfs_pkg;

  localparam int          HdrBytes      = 4;
  localparam int          MaxTokenBytes = 8;
  localparam logic [15:0] LimitReset    = 16'd256;
  localparam logic [7:0]  MarkerByte    = 8'hFF;

  localparam logic        ModeHeader  = 1'b0;
  localparam logic        ModePayload = 1'b1;

  localparam logic [1:0]  StOk       = 2'd0;
  localparam logic [1:0]  StBufSmall = 2'd1;
  localparam logic [1:0]  StTokLong  = 2'd2;
  localparam logic [1:0]  StNoRoom   = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_count;
    logic [7:0]  code_byte;
    logic [15:0] message_id;
    logic [63:0] token_bytes;
    logic [15:0] payload_count;
    logic [7:0]  payload_byte;
  } coap_in_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        is_last;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } coap_out_t;

endpackage

// File: hdl/cfs_cmp.sv
// Shared 16-bit magnitude compare unit of the serializer sequencer.
// Depends on nothing but its operands.
module cfs_cmp (
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic        ge_o
);
  assign ge_o = (a_i >= b_i);
endmodule

// File: hdl/cfs_byte_sel.sv
// Frame byte selector: header bytes, token bytes, payload marker by index.
// Depends on cfs_pkg.
module cfs_byte_sel (
  input  cfs_pkg::coap_in_t hdr_i,
  input  logic [3:0]        idx_i,
  input  logic [3:0]        ntok_i,
  output logic [7:0]        byte_o
);
  import cfs_pkg::*;

  logic [3:0] tok_off;
  logic [2:0] tok_idx;

  assign tok_off = idx_i - 4'(HdrBytes);
  assign tok_idx = tok_off[2:0];

  always_comb begin
    priority if (idx_i == 4'd0) begin
      byte_o = {hdr_i.version, hdr_i.msg_type, hdr_i.token_count};
    end else if (idx_i == 4'd1) begin
      byte_o = hdr_i.code_byte;
    end else if (idx_i == 4'd2) begin
      byte_o = hdr_i.message_id[15:8];
    end else if (idx_i == 4'd3) begin
      byte_o = hdr_i.message_id[7:0];
    end else if (tok_off < ntok_i) begin
      byte_o = hdr_i.token_bytes[{tok_idx, 3'b000} +: 8];
    end else begin
      byte_o = MarkerByte;
    end
  end
endmodule

// File: hdl/coap_frame_serializer.sv
// Header: limit/token/room checks, then one frame byte per cycle (4 to 13 bytes),
// unless the output stalls. Rejected header: one status transfer, then ready again.
// Payload item: at most one byte; not ready while an item is worked on.
// Sequencer shares one 16-bit compare unit across checks and byte emission.
// Reset: buffer_limit 256, no frame open, output empty.
`include "coap_frame_serializer_defines.svh"
module coap_frame_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cfs_pkg::coap_in_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cfs_pkg::coap_out_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);
  import cfs_pkg::*;

  localparam logic [2:0] SIdle    = 3'd0;
  localparam logic [2:0] SChkLim  = 3'd1;
  localparam logic [2:0] SChkTok  = 3'd2;
  localparam logic [2:0] SChkRoom = 3'd3;
  localparam logic [2:0] SEmit    = 3'd4;
  localparam logic [2:0] SPay     = 3'd5;
  localparam logic [2:0] SRej     = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [15:0] limit_q;
  logic [15:0] wpos_q, wpos_d;
  logic [15:0] pleft_q, pleft_d;
  logic        fopen_q, fopen_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  total_q, total_d;
  logic [1:0]  rej_q, rej_d;
  logic        out_valid_q, out_valid_d;
  coap_out_t   out_q, out_d;
  coap_in_t    hdr_q;

  logic        in_fire, slot_free, pnz, ge, room_small, last;
  logic [3:0]  room4, ntok, total_calc;
  logic [15:0] cmp_a, cmp_b, wpos_inc;
  logic [7:0]  sel_byte;

  assign in_ready_o  = (state_q == SIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign pnz        = (hdr_q.payload_count != 16'd0);
  assign room_small = (limit_q[15:4] == 12'd0);
  assign room4      = limit_q[3:0] - 4'(HdrBytes);
  assign ntok       = (room_small && (room4 < hdr_q.token_count)) ? room4 : hdr_q.token_count;
  assign total_calc = 4'(HdrBytes) + ntok + {3'b000, pnz};
  assign wpos_inc   = wpos_q + 16'd1;

  always_comb begin
    unique case (state_q)
      SChkLim: begin
        cmp_a = limit_q;
        cmp_b = 16'(HdrBytes);
      end
      SChkTok: begin
        cmp_a = {12'd0, hdr_q.token_count};
        cmp_b = 16'(MaxTokenBytes + 1);
      end
      SChkRoom: begin
        cmp_a = {12'd0, 4'(HdrBytes + 1) + ntok};
        cmp_b = limit_q;
      end
      SEmit: begin
        cmp_a = {12'd0, idx_q + 4'd1};
        cmp_b = {12'd0, total_q};
      end
      default: begin
        cmp_a = wpos_q;
        cmp_b = limit_q;
      end
    endcase
  end

  cfs_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .ge_o (ge)
  );

  cfs_byte_sel u_byte_sel (
    .hdr_i  (hdr_q),
    .idx_i  (idx_q),
    .ntok_i (ntok),
    .byte_o (sel_byte)
  );

  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    pleft_d     = pleft_q;
    fopen_d     = fopen_q;
    idx_d       = idx_q;
    total_d     = total_q;
    rej_d       = rej_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    last        = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          if (in_data_i.mode == ModeHeader) begin
            wpos_d  = 16'd0;
            pleft_d = 16'd0;
            fopen_d = 1'b0;
            state_d = SChkLim;
          end else if (fopen_q) begin
            pleft_d = pleft_q - 16'd1;
            fopen_d = (pleft_q != 16'd1);
            state_d = SPay;
          end
        end
      end
      SChkLim: begin
        if (ge) begin
          state_d = SChkTok;
        end else begin
          rej_d   = StBufSmall;
          state_d = SRej;
        end
      end
      SChkTok: begin
        if (ge) begin
          rej_d   = StTokLong;
          state_d = SRej;
        end else begin
          state_d = SChkRoom;
        end
      end
      SChkRoom: begin
        if (ge && pnz) begin
          rej_d   = StNoRoom;
          state_d = SRej;
        end else begin
          total_d = total_calc;
          idx_d   = 4'd0;
          wpos_d  = {12'd0, total_calc};
          pleft_d = hdr_q.payload_count;
          fopen_d = pnz;
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (slot_free) begin
          last               = ge && !pnz;
          out_valid_d        = 1'b1;
          out_d.byte_value   = sel_byte;
          out_d.is_last      = last;
          out_d.status       = StOk;
          out_d.frame_length = last ? {12'd0, total_q} : 16'd0;
          idx_d              = idx_q + 4'd1;
          if (ge) begin
            state_d = SIdle;
          end
        end
      end
      SPay: begin
        if (slot_free) begin
          if (!ge) begin
            last               = (pleft_q == 16'd0) || (wpos_inc == limit_q);
            out_valid_d        = 1'b1;
            out_d.byte_value   = hdr_q.payload_byte;
            out_d.is_last      = last;
            out_d.status       = StOk;
            out_d.frame_length = last ? wpos_inc : 16'd0;
            wpos_d             = wpos_inc;
          end
          state_d = SIdle;
        end
      end
      SRej: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.byte_value   = 8'd0;
          out_d.is_last      = 1'b1;
          out_d.status       = rej_q;
          out_d.frame_length = 16'd0;
          state_d            = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      limit_q     <= LimitReset;
      wpos_q      <= 16'd0;
      pleft_q     <= 16'd0;
      fopen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      pleft_q     <= pleft_d;
      fopen_q     <= fopen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    total_q <= total_d;
    rej_q   <= rej_d;
    out_q   <= out_d;
    if (in_fire) begin
      hdr_q <= in_data_i;
    end
  end

  `CFS_ASSERT_IMP(a_open_has_left, fopen_q, pleft_q != 16'd0, "open frame with no payload left")
  `CFS_ASSERT_IMP(a_emit_in_range, state_q == SEmit, idx_q < total_q, "emit index past frame end")
  `CFS_ASSERT_IMP(a_reject_shape, out_valid_o && (out_data_o.status != StOk),
                  out_data_o.is_last && (out_data_o.frame_length == 16'd0), "bad reject transfer")
  `CFS_ASSERT_NXT(a_hdr_closes, in_fire && (in_data_i.mode == ModeHeader),
                  !fopen_q && (wpos_q == 16'd0), "header did not close frame")

endmodule
